// ===== design/aho_corasick_match_counter_core_defines.svh =====
// Assertion macros for the matcher core
`ifndef AHO_CORASICK_MATCH_COUNTER_CORE_DEFINES_SVH
`define AHO_CORASICK_MATCH_COUNTER_CORE_DEFINES_SVH

// assert an implication whose consequent is checked in the next cycle
`define ACM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// assert a same-cycle implication
`define ACM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/acm_pkg.sv =====
`default_nettype none
package acm_pkg;
  localparam int unsigned MAX_NODES_DEF = 1024;
  localparam int unsigned ALPHABET_SIZE_DEF = 26;
  localparam logic [7:0] LETTER_BASE = 8'h61;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  localparam logic [2:0] OP_PAT_SYM = 3'd0;
  localparam logic [2:0] OP_PAT_END = 3'd1;
  localparam logic [2:0] OP_BUILD = 3'd2;
  localparam logic [2:0] OP_TEXT_SYM = 3'd3;
  localparam logic [2:0] OP_RESTART = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BADSYM = 2'd2;
  localparam logic [1:0] ST_ORDER = 2'd3;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] symbol;
  } in_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] match_count;
  } out_res_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? CNT_MAX : s[31:0];
  endfunction
endpackage
`default_nettype wire

// ===== design/acm_ram.sv =====
`default_nettype none
module acm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/aho_corasick_match_counter_core.sv =====
// Channel   Ports                         Handshake
// input     in_req (op, symbol)           start & !busy
// result    out_res (status, match_count) out_valid, one cycle, no stall
// After acceptance busy stays high through S_PRD for pattern symbol requests, through
// S_ERD for end-pattern requests and through S_TRD and S_TCNT for text symbols; restart
// and rejected requests do not raise it. The result is registered and shown when busy is low again.
// Build keeps busy high while it walks the trie through S_BNODE, S_BSUM, S_BSCAN and S_BLAST.
// After reset a clearing pass clears valid flags and counts; busy is high.
`default_nettype none
`include "aho_corasick_match_counter_core_defines.svh"
module aho_corasick_match_counter_core #(
  parameter int unsigned MAX_NODES = acm_pkg::MAX_NODES_DEF,
  parameter int unsigned ALPHABET_SIZE = acm_pkg::ALPHABET_SIZE_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire acm_pkg::in_req_t in_req,
  output logic                 busy,
  output logic                 out_valid,
  output acm_pkg::out_res_t    out_res
);
  localparam int unsigned NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int unsigned SLOTS = MAX_NODES * ALPHABET_SIZE;
  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned TW = NW + 1;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_PRD   = 11'b00000000100,
    S_PWR   = 11'b00000001000,
    S_ERD   = 11'b00000010000,
    S_TRD   = 11'b00000100000,
    S_TCNT  = 11'b00001000000,
    S_BNODE = 11'b00010000000,
    S_BSUM  = 11'b00100000000,
    S_BSCAN = 11'b01000000000,
    S_BLAST = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // goto memory: {valid, node}
  logic          g_we;
  logic [SW-1:0] g_wa, g_ra;
  logic [NW:0]   g_wd, g_rd;
  // second goto memory copy for reading the fail-state row
  logic [NW:0]   g2_rd;
  logic [SW-1:0] g2_ra;
  logic          e_we;
  logic [NW-1:0] e_wa, e_ra;
  logic [31:0]   e_wd, e_rd;
  logic          t_we;
  logic [NW-1:0] t_wa, t_ra;
  logic [31:0]   t_wd, t_rd;
  logic          f_we;
  logic [NW-1:0] f_wa, f_ra;
  logic [NW-1:0] f_wd, f_rd;
  logic          q_we;
  logic [NW-1:0] q_wa, q_ra;
  logic [NW-1:0] q_wd, q_rd;

  acm_ram #(.WIDTH(NW+1), .DEPTH(SLOTS)) u_goto (
    .clk, .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd));
  acm_ram #(.WIDTH(NW+1), .DEPTH(SLOTS)) u_goto2 (
    .clk, .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g2_ra), .rdata(g2_rd));
  acm_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_end (
    .clk, .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
  acm_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_tot (
    .clk, .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  acm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fail (
    .clk, .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
  acm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
    .clk, .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

  logic [SW-1:0] clr_r, clr_nxt;
  logic [TW-1:0] nodes_r, nodes_nxt;
  logic [NW-1:0] ins_r, ins_nxt, scan_r, scan_nxt;
  logic          built_r, built_nxt;
  logic [CW-1:0] let_r, let_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic [TW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [NW-1:0] v_r, v_nxt, f_r, f_nxt;
  logic          vld_r, vld_nxt;
  acm_pkg::out_res_t res_r, res_nxt;
  logic          valid_r, valid_nxt;
  logic          ver_r, ver_nxt;

  logic [8:0]    sym_off;
  logic          letter_ok;
  logic [CW-1:0] letter;

  assign sym_off   = {1'b0, in_req.symbol} - {1'b0, acm_pkg::LETTER_BASE};
  assign letter_ok = !sym_off[8] && (sym_off < 9'(ALPHABET_SIZE));
  assign letter    = sym_off[CW-1:0];

  function automatic logic [SW-1:0] slot(input logic [NW-1:0] n, input logic [CW-1:0] c);
    return SW'(n * ALPHABET_SIZE + c);
  endfunction

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r; nodes_nxt = nodes_r; ins_nxt = ins_r; scan_nxt = scan_r;
    built_nxt = built_r; let_nxt = let_r; c_nxt = c_r; head_nxt = head_r;
    tail_nxt = tail_r; v_nxt = v_r; f_nxt = f_r; vld_nxt = vld_r;
    res_nxt = res_r; valid_nxt = 1'b0; ver_nxt = ver_r;
    g_we = 1'b0; g_wa = '0; g_wd = '0; g_ra = '0; g2_ra = '0;
    e_we = 1'b0; e_wa = '0; e_wd = '0; e_ra = ins_r;
    t_we = 1'b0; t_wa = '0; t_wd = '0; t_ra = '0;
    f_we = 1'b0; f_wa = '0; f_wd = '0; f_ra = '0;
    q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;
    unique case (state_r)
      S_CLEAR: begin
        g_we = 1'b1; g_wa = clr_r; g_wd = '0;
        e_we = 1'b1; e_wa = clr_r[NW-1:0]; e_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == SW'(SLOTS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          res_nxt = '{status: acm_pkg::ST_OK, match_count: '0};
          let_nxt = letter;
          unique case (in_req.op)
            acm_pkg::OP_PAT_SYM: begin
              if (built_r) begin
                res_nxt.status = acm_pkg::ST_ORDER; valid_nxt = 1'b1;
              end else if (!letter_ok) begin
                res_nxt.status = acm_pkg::ST_BADSYM; valid_nxt = 1'b1;
              end else begin
                g_ra = slot(ins_r, letter); state_nxt = S_PRD;
              end
            end
            acm_pkg::OP_PAT_END: begin
              if (built_r) begin
                res_nxt.status = acm_pkg::ST_ORDER; valid_nxt = 1'b1;
              end else begin
                e_ra = ins_r; state_nxt = S_ERD;
              end
            end
            acm_pkg::OP_BUILD: begin
              if (built_r) begin
                res_nxt.status = acm_pkg::ST_ORDER; valid_nxt = 1'b1;
              end else begin
                e_ra = '0; state_nxt = S_BNODE;
                head_nxt = '0; tail_nxt = '0; v_nxt = '0; f_nxt = '0;
                vld_nxt = 1'b0; c_nxt = '0;
              end
            end
            acm_pkg::OP_TEXT_SYM: begin
              if (!built_r) begin
                res_nxt.status = acm_pkg::ST_ORDER; valid_nxt = 1'b1;
              end else if (!letter_ok) begin
                res_nxt.status = acm_pkg::ST_BADSYM; valid_nxt = 1'b1;
              end else begin
                g_ra = slot(scan_r, letter); state_nxt = S_TRD;
              end
            end
            acm_pkg::OP_RESTART: begin
              scan_nxt = '0; valid_nxt = 1'b1;
            end
            default: begin
              res_nxt.status = acm_pkg::ST_ORDER; valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_PRD: begin
        valid_nxt = 1'b1; state_nxt = S_IDLE;
        if (g_rd[NW]) begin
          ins_nxt = g_rd[NW-1:0];
        end else if (nodes_r >= TW'(MAX_NODES)) begin
          res_nxt.status = acm_pkg::ST_FULL;
        end else begin
          g_we = 1'b1; g_wa = slot(ins_r, let_r); g_wd = {1'b1, nodes_r[NW-1:0]};
          ins_nxt = nodes_r[NW-1:0]; nodes_nxt = nodes_r + 1'b1;
        end
      end
      S_ERD: begin
        e_we = 1'b1; e_wa = ins_r; e_wd = acm_pkg::sat_add(e_rd, 32'd1);
        ins_nxt = '0; valid_nxt = 1'b1; state_nxt = S_IDLE;
      end
      S_TRD: begin
        scan_nxt = g_rd[NW-1:0]; t_ra = g_rd[NW-1:0]; state_nxt = S_TCNT;
      end
      S_TCNT: begin
        res_nxt.match_count = t_rd; valid_nxt = 1'b1; state_nxt = S_IDLE;
      end
      // node setup: e_rd = end_count[v], f_rd = fail[v] (when vld_r)
      S_BNODE: begin
        if (!vld_r) begin
          // root
          t_we = 1'b1; t_wa = '0; t_wd = e_rd;
          f_nxt = '0; c_nxt = '0; ver_nxt = 1'b0;
          g_ra = slot('0, '0); g2_ra = slot('0, '0);
          state_nxt = S_BSCAN;
        end else begin
          // keep end_count[v] on the read port for the sum
          e_ra = v_r;
          f_nxt = f_rd; t_ra = f_rd; state_nxt = S_BSUM;
        end
      end
      S_BSUM: begin
        t_we = 1'b1; t_wa = v_r; t_wd = acm_pkg::sat_add(e_rd, t_rd);
        c_nxt = '0; ver_nxt = 1'b0;
        g_ra = slot(v_r, '0); g2_ra = slot(f_r, '0);
        state_nxt = S_BSCAN;
      end
      // each letter is first read, then acted on
      S_BSCAN: begin
        if (!ver_r) begin
          g_ra = slot(v_r, c_r); g2_ra = slot(f_r, c_r); ver_nxt = 1'b1;
        end else begin
          ver_nxt = 1'b0;
          if (g_rd[NW]) begin
            f_we = 1'b1; f_wa = g_rd[NW-1:0];
            f_wd = vld_r ? g2_rd[NW-1:0] : '0;
            if (tail_r < TW'(MAX_NODES)) begin
              q_we = 1'b1; q_wa = tail_r[NW-1:0]; q_wd = g_rd[NW-1:0];
              tail_nxt = tail_r + 1'b1;
            end
          end else begin
            g_we = 1'b1; g_wa = slot(v_r, c_r);
            g_wd = {1'b1, vld_r ? g2_rd[NW-1:0] : NW'(0)};
          end
          if (c_r == CW'(ALPHABET_SIZE - 1)) begin
            state_nxt = S_BLAST;
          end else begin
            c_nxt = c_r + 1'b1;
            g_ra = slot(v_r, c_r + 1'b1); g2_ra = slot(f_r, c_r + 1'b1);
          end
        end
      end
      S_BLAST: begin
        q_ra = head_r[NW-1:0];
        if (head_r < tail_r) begin
          state_nxt = S_BLAST;
          vld_nxt = 1'b0;
          if (!vld_r || ver_r == 1'b0) begin
            ver_nxt = 1'b1; // queue read issued
            vld_nxt = vld_r;
            if (ver_r) state_nxt = S_BLAST;
          end
          if (ver_r) begin
            v_nxt = q_rd; f_ra = q_rd; e_ra = q_rd;
            head_nxt = head_r + 1'b1; vld_nxt = 1'b1; ver_nxt = 1'b0;
            state_nxt = S_BNODE;
          end
        end else begin
          built_nxt = 1'b1; ins_nxt = '0; scan_nxt = '0;
          valid_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; nodes_r <= TW'(1); ins_r <= '0;
      scan_r <= '0; built_r <= 1'b0; valid_r <= 1'b0; vld_r <= 1'b0;
      ver_r <= 1'b0; head_r <= '0; tail_r <= '0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt; nodes_r <= nodes_nxt;
      ins_r <= ins_nxt; scan_r <= scan_nxt; built_r <= built_nxt;
      valid_r <= valid_nxt; vld_r <= vld_nxt; ver_r <= ver_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    let_r <= let_nxt; c_r <= c_nxt; v_r <= v_nxt; f_r <= f_nxt; res_r <= res_nxt;
  end

  `ACM_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy && in_req.op == acm_pkg::OP_BUILD && !built_r, busy)
  `ACM_ASSERT_NOW(a_nodes_range, clk, rst_n, 1'b1, nodes_r <= TW'(MAX_NODES) && nodes_r != '0)
  `ACM_ASSERT_NOW(a_head_tail, clk, rst_n, 1'b1, head_r <= tail_r)
  `ACM_ASSERT_NEXT(a_text_order, clk, rst_n, start && !busy && in_req.op == acm_pkg::OP_TEXT_SYM && !built_r, out_valid && out_res.status == acm_pkg::ST_ORDER)
endmodule
`default_nettype wire

// ===== test/tb_aho_corasick_match_counter_core.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_aho_corasick_match_counter_core;
  import acm_pkg::*;

  localparam int unsigned NODES = MAX_NODES_DEF;
  localparam int unsigned ALPHA = ALPHABET_SIZE_DEF;
  localparam int unsigned ITEM_TARGET = 1950;

  class acm_scoreboard;
    int unsigned goto_next[NODES*ALPHA];
    bit          goto_set[NODES*ALPHA];
    int unsigned fail_to[NODES];
    int unsigned pat_cnt[NODES];
    int unsigned chain_cnt[NODES];
    int unsigned bfs_q[NODES];
    int unsigned node_cnt;
    int unsigned ins_node;
    int unsigned scan_node;
    bit          is_built;
    out_res_t    pending[$];
    int          errors;
    int          checked;
    int          hits;
    int          full_seen;

    function new();
      node_cnt = 1;
      ins_node = 0;
      scan_node = 0;
      is_built = 0;
      errors = 0;
      checked = 0;
      hits = 0;
      full_seen = 0;
    endfunction

    function int unsigned add_clip(int unsigned a, int unsigned b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function int letter_idx(logic [7:0] sym);
      if (sym < LETTER_BASE) return -1;
      if (sym - LETTER_BASE >= ALPHA) return -1;
      return int'(sym - LETTER_BASE);
    endfunction

    function void build_automaton();
      int unsigned head, tail, v, f, nx, s, fs;
      head = 0;
      tail = 0;
      chain_cnt[0] = pat_cnt[0];
      for (int c = 0; c < ALPHA; c++) begin
        if (goto_set[c]) begin
          nx = goto_next[c] % NODES;
          fail_to[nx] = 0;
          if (tail < NODES) begin
            bfs_q[tail] = nx;
            tail++;
          end
        end else begin
          goto_next[c] = 0;
          goto_set[c] = 1;
        end
      end
      while (head < tail) begin
        v = bfs_q[head] % NODES;
        head++;
        f = fail_to[v] % NODES;
        chain_cnt[v] = add_clip(pat_cnt[v], chain_cnt[f]);
        for (int c = 0; c < ALPHA; c++) begin
          s = v * ALPHA + c;
          fs = f * ALPHA + c;
          if (goto_set[s]) begin
            nx = goto_next[s] % NODES;
            fail_to[nx] = goto_next[fs] % NODES;
            if (tail < NODES) begin
              bfs_q[tail] = nx;
              tail++;
            end
          end else begin
            goto_next[s] = goto_next[fs] % NODES;
            goto_set[s] = 1;
          end
        end
      end
      is_built = 1;
      ins_node = 0;
      scan_node = 0;
    endfunction

    function void note_input(in_req_t r);
      out_res_t e;
      int c;
      int unsigned s;
      c = letter_idx(r.symbol);
      e.status = ST_OK;
      e.match_count = 0;
      case (r.op)
        OP_PAT_SYM: begin
          if (is_built) e.status = ST_ORDER;
          else if (c < 0) e.status = ST_BADSYM;
          else begin
            s = ins_node * ALPHA + c;
            if (goto_set[s]) ins_node = goto_next[s] % NODES;
            else if (node_cnt >= NODES) begin
              e.status = ST_FULL;
              full_seen++;
            end else begin
              goto_next[s] = node_cnt;
              goto_set[s] = 1;
              ins_node = node_cnt;
              node_cnt++;
            end
          end
        end
        OP_PAT_END: begin
          if (is_built) e.status = ST_ORDER;
          else begin
            pat_cnt[ins_node] = add_clip(pat_cnt[ins_node], 1);
            ins_node = 0;
          end
        end
        OP_BUILD: begin
          if (is_built) e.status = ST_ORDER;
          else build_automaton();
        end
        OP_TEXT_SYM: begin
          if (!is_built) e.status = ST_ORDER;
          else if (c < 0) e.status = ST_BADSYM;
          else begin
            scan_node = goto_next[scan_node * ALPHA + c] % NODES;
            e.match_count = chain_cnt[scan_node];
            if (e.match_count != 0) hits++;
          end
        end
        OP_RESTART: scan_node = 0;
        default: e.status = ST_ORDER;
      endcase
      pending = {pending, e};
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(out_res_t r);
      out_res_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result status=%0d count=%0d", r.status, r.match_count));
        return;
      end
      e = pending.pop_front();
      checked++;
      if (r.status !== e.status)
        report($sformatf("status %0d, want %0d", r.status, e.status));
      if (r.match_count !== e.match_count)
        report($sformatf("match_count %0d, want %0d", r.match_count, e.match_count));
    endtask
  endclass

  logic     clk;
  logic     rst_n;
  logic     start;
  in_req_t  in_req;
  logic     busy;
  logic     out_valid;
  out_res_t out_res;

  acm_scoreboard sb;
  int sent;
  int burst_left;

  aho_corasick_match_counter_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_req   (in_req),
    .busy     (busy),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("tb_aho_corasick_match_counter_core failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_res);
  end

  // one request; returns right after the edge that took it
  task send(logic [2:0] op, logic [7:0] sym);
    in_req_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
    burst_left--;
    r.op = op;
    r.symbol = sym;
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    sb.note_input(r);
    sent++;
  endtask

  task drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function logic [7:0] pick_letter(int unsigned span);
    return 8'(LETTER_BASE + $urandom_range(0, span - 1));
  endfunction

  task send_pattern(int unsigned len, int unsigned span);
    for (int i = 0; i < len; i++) send(OP_PAT_SYM, pick_letter(span));
    send(OP_PAT_END, 8'($urandom_range(0, 255)));
  endtask

  task pattern_noise();
    int unsigned k;
    k = $urandom_range(0, 3);
    case (k)
      0: send(OP_PAT_SYM, 8'($urandom_range(0, 1) ? $urandom_range(0, 8'h60)
                                                  : $urandom_range(8'h7b, 8'hff)));
      1: send(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)));
      2: send(OP_TEXT_SYM, 8'($urandom_range(0, 255)));
      default: send(OP_RESTART, 8'($urandom_range(0, 255)));
    endcase
  endtask

  initial begin
    int unsigned k;
    sb = new();
    sent = 0;
    burst_left = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // before the build: order errors, bad bytes, empty pattern, short patterns
    send(OP_TEXT_SYM, "a");
    send(OP_RESTART, 8'h00);
    send(3'd5, 8'hff);
    send(3'd6, 8'h55);
    send(3'd7, 8'haa);
    send(OP_PAT_SYM, 8'h00);
    send(OP_PAT_SYM, 8'h60);
    send(OP_PAT_SYM, 8'h7b);
    send(OP_PAT_SYM, 8'hff);
    send(OP_PAT_END, 8'h00);
    send(OP_PAT_SYM, "a"); send(OP_PAT_END, 8'hff);
    send(OP_PAT_SYM, "a"); send(OP_PAT_SYM, "b"); send(OP_PAT_END, 8'h00);
    send(OP_PAT_SYM, "b"); send(OP_PAT_SYM, "c"); send(OP_PAT_END, 8'h00);
    send(OP_PAT_SYM, "z"); send(OP_PAT_END, 8'h00);

    while (sent < 500) begin
      k = $urandom_range(0, 9);
      if (k < 6) send_pattern($urandom_range(0, 4), 3);
      else if (k < 8) send_pattern($urandom_range(4, 10), ALPHA);
      else pattern_noise();
    end
    drain();

    // push the trie to its node limit, then overflow it
    while (sb.node_cnt < NODES) send_pattern($urandom_range(6, 16), ALPHA);
    for (int i = 0; i < 8; i++) send(OP_PAT_SYM, pick_letter(ALPHA));
    send_pattern(2, 3);
    // left unfinished across the build
    send(OP_PAT_SYM, "a");
    send(OP_BUILD, 8'($urandom_range(0, 255)));

    // after the build
    send(OP_PAT_SYM, "a");
    send(OP_PAT_END, 8'h00);
    send(OP_BUILD, 8'h00);
    send(OP_TEXT_SYM, 8'h60);
    send(OP_TEXT_SYM, 8'h7b);
    send(OP_TEXT_SYM, 8'hff);
    send(OP_TEXT_SYM, "a");
    send(OP_TEXT_SYM, "b");
    send(OP_TEXT_SYM, "z");
    send(OP_RESTART, 8'h00);

    while (sent < ITEM_TARGET) begin
      k = $urandom_range(0, 99);
      if (k < 75) send(OP_TEXT_SYM, pick_letter(3));
      else if (k < 87) send(OP_TEXT_SYM, pick_letter(ALPHA));
      else if (k < 92) send(OP_TEXT_SYM, 8'($urandom_range(0, 1) ? $urandom_range(0, 8'h60)
                                                              : $urandom_range(8'h7b, 8'hff)));
      else if (k < 96) send(OP_RESTART, 8'($urandom_range(0, 255)));
      else send(3'($urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(5, 7)),
                8'($urandom_range(0, 255)));
    end

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d requests, %0d results checked: trie of %0d nodes,",
             sent, sb.checked, sb.node_cnt);
    $display("%0d overflowed symbols, %0d text positions with matches",
             sb.full_seen, sb.hits);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_aho_corasick_match_counter_core passed");
    end else begin
      $display("tb_aho_corasick_match_counter_core failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+design
design/acm_pkg.sv
design/acm_ram.sv
design/aho_corasick_match_counter_core.sv
test/tb_aho_corasick_match_counter_core.sv
